/* rtl/lkvc_pkg.sv */
// shared types, command codes and defaults for the lru key-value cache
package lkvc_pkg;

   // default sizes handed to the top level parameters
   localparam int ENTRIES_DEF    = 16;
   localparam int KEY_BITS_DEF   = 64;
   localparam int VALUE_BITS_DEF = 64;
   localparam int COUNT_BITS_DEF = 32;

   // fixed field widths of the channels
   localparam int CMD_W   = 3;
   localparam int FIELD_W = 64;
   localparam int SMALL_W = 5;
   localparam int TOTAL_W = 32;

   // register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_LIMIT = 1'b0;
   localparam logic [SMALL_W-1:0] LIMIT_RESET = 5'd16;

   typedef logic [CMD_W-1:0] command_type;

   localparam command_type CMD_LOOKUP = 3'd0;
   localparam command_type CMD_INSERT = 3'd1;
   localparam command_type CMD_REMOVE = 3'd2;
   localparam command_type CMD_CLEAR  = 3'd3;
   localparam command_type CMD_TRIM   = 3'd4;

   // per-cycle shift controls broadcast along the cell row
   typedef struct packed {
      logic move_front;
      logic remove_hit;
   } cell_cmd_type;

endpackage

/* rtl/lkvc_req_if.sv */
// request channel carrying one cache command item
interface lkvc_req_if;
   import lkvc_pkg::*;

   logic               valid;
   logic               ready;
   command_type        command;
   logic [FIELD_W-1:0] lookup_key;
   logic [FIELD_W-1:0] write_value;

   modport source(output valid, command, lookup_key, write_value, input ready);
   modport sink(input valid, command, lookup_key, write_value, output ready);
endinterface

/* rtl/lkvc_rsp_if.sv */
// response channel carrying one cache result item
interface lkvc_rsp_if;
   import lkvc_pkg::*;

   logic               valid;
   logic               ready;
   logic               hit;
   logic [FIELD_W-1:0] read_value;
   logic [SMALL_W-1:0] evicted_now;
   logic [SMALL_W-1:0] occupancy;
   logic [TOTAL_W-1:0] hit_total;
   logic [TOTAL_W-1:0] miss_total;
   logic [TOTAL_W-1:0] eviction_total;

   modport source(output valid, hit, read_value, evicted_now, occupancy, hit_total,
                  miss_total, eviction_total, input ready);
   modport sink(input valid, hit, read_value, evicted_now, occupancy, hit_total,
                miss_total, eviction_total, output ready);
endinterface

/* rtl/lkvc_cell.sv */
// one recency slot: holds a key and value, compares, shifts with its neighbors
module lkvc_cell #(
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64
) (
   input  logic                  clock,
   input  lkvc_pkg::cell_cmd_type cmd,
   input  logic                  entry_valid,
   input  logic [KEY_BITS-1:0]   probe_key,
   input  logic [KEY_BITS-1:0]   left_key,
   input  logic [VALUE_BITS-1:0] left_value,
   input  logic [KEY_BITS-1:0]   right_key,
   input  logic [VALUE_BITS-1:0] right_value,
   input  logic                  seen_in,
   input  logic [VALUE_BITS-1:0] found_in,
   output logic [KEY_BITS-1:0]   key_out,
   output logic [VALUE_BITS-1:0] value_out,
   output logic                  seen_out,
   output logic [VALUE_BITS-1:0] found_out
);

   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  match;
   logic                  first;

   // compare and pass the first match down the row
   assign match     = entry_valid && (key_ff == probe_key);
   assign first     = match && !seen_in;
   assign seen_out  = seen_in || match;
   assign found_out = found_in | (first ? value_ff : '0);
   assign key_out   = key_ff;
   assign value_out = value_ff;

   // take from the more recent neighbor, the older neighbor, or hold
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (cmd.move_front && !seen_in) begin
         key_in   = left_key;
         value_in = left_value;
      end else if (cmd.remove_hit && seen_out) begin
         key_in   = right_key;
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

/* rtl/lkvc_chain.sv */
// row of recency cells, most recent at the head, with the match chain
module lkvc_chain #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64,
   parameter int CNT_W      = $clog2(ENTRIES + 1)
) (
   input  logic                   clock,
   input  logic                   apply,
   input  lkvc_pkg::command_type  command,
   input  logic [KEY_BITS-1:0]    probe_key,
   input  logic [VALUE_BITS-1:0]  write_value,
   input  logic [CNT_W-1:0]       count,
   output logic                   hit,
   output logic [VALUE_BITS-1:0]  found_value
);
   import lkvc_pkg::*;

   logic [KEY_BITS-1:0]   key_q   [ENTRIES];
   logic [VALUE_BITS-1:0] value_q [ENTRIES];
   logic                  seen    [ENTRIES+1];
   logic [VALUE_BITS-1:0] found   [ENTRIES+1];
   logic [VALUE_BITS-1:0] front_value;
   cell_cmd_type          cmd;

   assign seen[0]     = 1'b0;
   assign found[0]    = '0;
   assign hit         = seen[ENTRIES];
   assign found_value = found[ENTRIES];

   // broadcast controls; insert writes its value, a lookup hit moves the old one
   assign cmd.move_front = apply && ((command == CMD_INSERT) ||
                                     ((command == CMD_LOOKUP) && hit));
   assign cmd.remove_hit = apply && (command == CMD_REMOVE) && hit;
   assign front_value    = (command == CMD_INSERT) ? write_value : found_value;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [KEY_BITS-1:0]   lkey, rkey;
      logic [VALUE_BITS-1:0] lval, rval;
      logic                  valid;

      // head takes the front item, tail sees an empty older neighbor
      if (i == 0) begin : g_head
         assign lkey = probe_key;
         assign lval = front_value;
      end else begin : g_mid
         assign lkey = key_q[i-1];
         assign lval = value_q[i-1];
      end
      if (i == ENTRIES - 1) begin : g_tail
         assign rkey = '0;
         assign rval = '0;
      end else begin : g_body
         assign rkey = key_q[i+1];
         assign rval = value_q[i+1];
      end

      // occupied slots are the first count cells
      assign valid = CNT_W'(i) < count;

      lkvc_cell #(
         .KEY_BITS  (KEY_BITS),
         .VALUE_BITS(VALUE_BITS)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .entry_valid(valid),
         .probe_key  (probe_key),
         .left_key   (lkey),
         .left_value (lval),
         .right_key  (rkey),
         .right_value(rval),
         .seen_in    (seen[i]),
         .found_in   (found[i]),
         .key_out    (key_q[i]),
         .value_out  (value_q[i]),
         .seen_out   (seen[i+1]),
         .found_out  (found[i+1])
      );
   end

endmodule

/* rtl/lru_key_value_cache.sv */
// top level: command sequencer, occupancy and counters, register port, result stage
// an accepted item waits in S_APPLY while a result is pending; its result is then registered
// a new item is accepted only in S_IDLE, after the compare-and-shift pass of the cell row
// evictions of any length finish in that same pass by trimming the row's tail
// reset (synchronous): store empty, counters zero, entry limit 16; no clearing pass
module lru_key_value_cache #(
   parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
   parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF,
   parameter int COUNT_BITS = lkvc_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   lkvc_req_if.sink                          req_if,
   lkvc_rsp_if.source                        rsp_if,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lkvc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lkvc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lkvc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import lkvc_pkg::*;

   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > SMALL_W) ? CNT_W : SMALL_W;
   localparam int SUM_W = ((COUNT_BITS > CNT_W) ? COUNT_BITS : CNT_W) + 1;

   localparam logic S_IDLE  = 1'b0;
   localparam logic S_APPLY = 1'b1;

   logic                  state_ff, state_in;
   command_type           cmd_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] wval_ff;
   logic [SMALL_W-1:0]    limit_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [COUNT_BITS-1:0] hits_ff, hits_in;
   logic [COUNT_BITS-1:0] misses_ff, misses_in;
   logic [COUNT_BITS-1:0] evicts_ff, evicts_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff;
   logic [FIELD_W-1:0]    rsp_value_ff;
   logic [SMALL_W-1:0]    rsp_evicted_ff;
   logic [SMALL_W-1:0]    rsp_occ_ff;

   logic                  req_take;
   logic                  apply;
   logic                  chain_hit;
   logic [VALUE_BITS-1:0] found_value;
   logic [CMP_W-1:0]      lim_wide, ent_wide;
   logic [CNT_W-1:0]      limit_eff;
   logic [CNT_W-1:0]      insert_target;
   logic [CNT_W-1:0]      trim_target;
   logic [CNT_W-1:0]      evicted;
   logic [SUM_W-1:0]      evict_sum;
   logic                  cmd_hit;
   logic                  csr_write;

   // handshakes
   assign req_if.ready = (state_ff == S_IDLE);
   assign req_take     = req_if.valid && (state_ff == S_IDLE);
   assign apply        = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_if.ready);

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_LIMIT);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_LIMIT) ?
                       CSR_DATA_W'(limit_ff) : '0;

   lkvc_chain #(
      .ENTRIES   (ENTRIES),
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS),
      .CNT_W     (CNT_W)
   ) u_chain (
      .clock      (clock),
      .apply      (apply),
      .command    (cmd_ff),
      .probe_key  (key_ff),
      .write_value(wval_ff),
      .count      (count_ff),
      .hit        (chain_hit),
      .found_value(found_value)
   );

   // effective limit and eviction targets
   assign lim_wide  = CMP_W'(limit_ff);
   assign ent_wide  = CMP_W'(ENTRIES);
   assign limit_eff = CNT_W'((lim_wide > ent_wide) ? ent_wide : lim_wide);

   always_comb begin
      if (limit_eff == '0) begin
         insert_target = '0;
      end else if (count_ff >= limit_eff) begin
         insert_target = limit_eff - 1'b1;
      end else begin
         insert_target = count_ff;
      end
   end

   assign trim_target = (count_ff > limit_eff) ? limit_eff : count_ff;

   // command decode: occupancy, evictions, hit and miss counters
   always_comb begin
      count_in  = count_ff;
      evicted   = '0;
      hits_in   = hits_ff;
      misses_in = misses_ff;
      cmd_hit   = 1'b0;
      unique case (cmd_ff)
         CMD_LOOKUP: begin
            cmd_hit = chain_hit;
            if (chain_hit) begin
               hits_in = (hits_ff == '1) ? hits_ff : hits_ff + 1'b1;
            end else begin
               misses_in = (misses_ff == '1) ? misses_ff : misses_ff + 1'b1;
            end
         end
         CMD_INSERT: begin
            cmd_hit = chain_hit;
            if (!chain_hit) begin
               evicted  = count_ff - insert_target;
               count_in = insert_target + 1'b1;
            end
         end
         CMD_REMOVE: begin
            cmd_hit = chain_hit;
            if (chain_hit) begin
               count_in = count_ff - 1'b1;
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         CMD_TRIM: begin
            evicted  = count_ff - trim_target;
            count_in = trim_target;
         end
         default: begin
         end
      endcase
   end

   // saturating eviction total
   assign evict_sum = SUM_W'(evicts_ff) + SUM_W'(evicted);
   assign evicts_in = (|evict_sum[SUM_W-1:COUNT_BITS]) ? '1 : evict_sum[COUNT_BITS-1:0];

   // sequencer and result valid
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_take) state_in = S_APPLY;
         S_APPLY: if (apply) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = apply ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         count_ff     <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            limit_ff <= csr_pwdata[SMALL_W-1:0];
         end
         if (apply) begin
            count_ff  <= count_in;
            hits_ff   <= hits_in;
            misses_ff <= misses_in;
            evicts_ff <= evicts_in;
         end
      end
   end

   // accepted item and result payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff  <= req_if.command;
         key_ff  <= req_if.lookup_key[KEY_BITS-1:0];
         wval_ff <= req_if.write_value[VALUE_BITS-1:0];
      end
      if (apply) begin
         rsp_hit_ff     <= cmd_hit;
         rsp_value_ff   <= (cmd_ff == CMD_LOOKUP) ? FIELD_W'(found_value) : '0;
         rsp_evicted_ff <= SMALL_W'(evicted);
         rsp_occ_ff     <= SMALL_W'(count_in);
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.hit            = rsp_hit_ff;
   assign rsp_if.read_value     = rsp_value_ff;
   assign rsp_if.evicted_now    = rsp_evicted_ff;
   assign rsp_if.occupancy      = rsp_occ_ff;
   assign rsp_if.hit_total      = TOTAL_W'(hits_ff);
   assign rsp_if.miss_total     = TOTAL_W'(misses_ff);
   assign rsp_if.eviction_total = TOTAL_W'(evicts_ff);

endmodule
